// File: rtl/stt_pkg.sv
// shared types, token codes and character classes for the source text tokenizer
package stt_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int LEN_BITS          = 16;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_BITS     = $clog2(FIFO_DEPTH);

    typedef enum logic [3:0] {
        M_START  = 4'd0,
        M_SLASH  = 4'd1,
        M_LINE   = 4'd2,
        M_BLOCK  = 4'd3,
        M_BSTAR  = 4'd4,
        M_CHAR1  = 4'd5,
        M_CHAR2  = 4'd6,
        M_STRING = 4'd7,
        M_IDENT  = 4'd8,
        M_NUMBER = 4'd9,
        M_OPER   = 4'd10,
        M_HALT   = 4'd11
    } t_mode;

    // token kinds
    localparam logic [4:0] K_EOF    = 5'd0;
    localparam logic [4:0] K_PLUS   = 5'd1;
    localparam logic [4:0] K_MINUS  = 5'd2;
    localparam logic [4:0] K_MULT   = 5'd3;
    localparam logic [4:0] K_DIV    = 5'd4;
    localparam logic [4:0] K_LPAREN = 5'd5;
    localparam logic [4:0] K_RPAREN = 5'd6;
    localparam logic [4:0] K_LBRACK = 5'd7;
    localparam logic [4:0] K_RBRACK = 5'd8;
    localparam logic [4:0] K_LBRACE = 5'd9;
    localparam logic [4:0] K_RBRACE = 5'd10;
    localparam logic [4:0] K_SEMI   = 5'd11;
    localparam logic [4:0] K_COMMA  = 5'd12;
    localparam logic [4:0] K_LIT    = 5'd13;
    localparam logic [4:0] K_ID     = 5'd14;
    localparam logic [4:0] K_NUM    = 5'd15;
    localparam logic [4:0] K_ASSIGN = 5'd16;
    localparam logic [4:0] K_RELOP  = 5'd17;
    localparam logic [4:0] K_ERR    = 5'd18;

    // token attributes
    localparam logic [3:0] A_NONE = 4'd0;
    localparam logic [3:0] A_CHAR = 4'd1;
    localparam logic [3:0] A_STR  = 4'd2;
    localparam logic [3:0] A_EQ   = 4'd3;
    localparam logic [3:0] A_GT   = 4'd4;
    localparam logic [3:0] A_GE   = 4'd5;
    localparam logic [3:0] A_LT   = 4'd6;
    localparam logic [3:0] A_LE   = 4'd7;
    localparam logic [3:0] A_NOT  = 4'd8;
    localparam logic [3:0] A_NE   = 4'd9;
    localparam logic [3:0] A_AND  = 4'd10;
    localparam logic [3:0] A_OR   = 4'd11;

    // pending operator codes
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_EQ   = 3'd1;
    localparam logic [2:0] OP_GT   = 3'd2;
    localparam logic [2:0] OP_LT   = 3'd3;
    localparam logic [2:0] OP_NOT  = 3'd4;
    localparam logic [2:0] OP_AMP  = 3'd5;
    localparam logic [2:0] OP_BAR  = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [4:0]          kind;
        logic [3:0]          attr;
        logic [15:0]         start;
        logic [LEN_BITS-1:0] length;
        logic                last;
    } t_token;

    typedef struct packed {
        logic       emit;
        logic [4:0] kind;
        logic       len_one;
        logic       eof;
        t_mode      mode;
        logic [2:0] op;
    } t_begin;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_print(input logic [7:0] b);
        return (b >= 8'd32) && (b <= 8'd126);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_MINUS;
            8'h2A:   k = K_MULT;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] oper_code(input logic [7:0] b);
        logic [2:0] c;
        unique case (b)
            8'h3D:   c = OP_EQ;
            8'h3E:   c = OP_GT;
            8'h3C:   c = OP_LT;
            8'h21:   c = OP_NOT;
            8'h26:   c = OP_AMP;
            8'h7C:   c = OP_BAR;
            default: c = OP_NONE;
        endcase
        return c;
    endfunction

    // what a byte does when it opens a new token
    function automatic t_begin begin_token(input logic [7:0] b);
        t_begin r;
        r.emit    = 1'b0;
        r.kind    = K_EOF;
        r.len_one = 1'b1;
        r.eof     = 1'b0;
        r.mode    = M_START;
        r.op      = OP_NONE;
        priority if (b == CH_NUL) begin
            r.emit    = 1'b1;
            r.len_one = 1'b0;
            r.eof     = 1'b1;
        end else if (is_space(b)) begin
            r.emit = 1'b0;
        end else if (single_kind(b) != K_EOF) begin
            r.emit = 1'b1;
            r.kind = single_kind(b);
        end else if (oper_code(b) != OP_NONE) begin
            r.op   = oper_code(b);
            r.mode = M_OPER;
        end else if (b == CH_SLASH) begin
            r.mode = M_SLASH;
        end else if (b == CH_QUOTE) begin
            r.mode = M_CHAR1;
        end else if (b == CH_DQUOTE) begin
            r.mode = M_STRING;
        end else if (is_alpha(b)) begin
            r.mode = M_IDENT;
        end else if (is_digit(b)) begin
            r.mode = M_NUMBER;
        end else begin
            r.emit = 1'b1;
            r.kind = K_ERR;
            r.mode = M_HALT;
        end
        return r;
    endfunction

endpackage

// File: rtl/source_text_tokenizer_top.sv
// source text tokenizer: byte-in scanner with a small result queue
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  text     | in        | i_in_valid / o_in_stall   | i_text_byte
//  token    | out       | o_out_valid / i_out_stall | o_token_kind, o_token_attr,
//           |           |                        | o_token_start, o_token_length,
//           |           |                        | o_last_of_run
//
//  one byte is taken per cycle while the text side is not stalled; the scan mode register is updated in the same cycle
//  a byte yields zero, one or two tokens, written into a four-entry result queue
//  the text side stalls while fewer than two queue entries are free
//  a token is registered in the queue as its byte is taken and shown once the tokens ahead of it are gone
//  synchronous active-low reset empties the queue and returns the scanner to start
//  after an error token all further bytes are taken and dropped until reset
module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_text_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [4:0]          o_token_kind,
    output logic [3:0]          o_token_attr,
    output logic [15:0]         o_token_start,
    output logic [LEN_BITS-1:0] o_token_length,
    output logic                o_last_of_run
);

    t_mode                    r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [2:0]               r_op, n_op;
    logic [LEN_BITS-1:0]      r_run, n_run;

    t_token                   r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr, r_rd;
    logic [FIFO_PTR_BITS:0]   r_cnt, n_cnt;

    logic                accept, pop;
    logic [7:0]          b;
    logic [LEN_BITS-1:0] incl;
    t_begin              bg;
    logic                do_begin;
    logic                a_v;
    logic [4:0]          a_kind;
    logic [3:0]          a_attr;
    logic [LEN_BITS-1:0] a_len;
    logic                b_v;
    t_token              e0, e1;
    logic [1:0]          n_push;

    assign accept = i_in_valid && !o_in_stall;
    assign pop    = o_out_valid && !i_out_stall;
    assign b      = i_text_byte;
    assign incl   = (r_run == '1) ? r_run : r_run + LEN_BITS'(1);
    assign bg     = begin_token(b);

    always_comb begin
        n_mode   = r_mode;
        n_op     = r_op;
        n_start  = r_start;
        n_run    = r_run;
        do_begin = 1'b0;
        a_v      = 1'b0;
        a_kind   = K_ERR;
        a_attr   = A_NONE;
        a_len    = incl;
        unique case (r_mode)
            M_SLASH: begin
                if (b == CH_SLASH) begin
                    n_mode = M_LINE;
                    n_run  = incl;
                end else if (b == CH_STAR) begin
                    n_mode = M_BLOCK;
                    n_run  = incl;
                end else begin
                    a_v      = 1'b1;
                    a_kind   = K_DIV;
                    a_len    = LEN_BITS'(1);
                    do_begin = 1'b1;
                end
            end
            M_LINE: begin
                if (b == CH_NL) begin
                    n_mode = M_START;
                end else if (b == CH_NUL) begin
                    do_begin = 1'b1;
                end
            end
            M_BLOCK, M_BSTAR: begin
                if (b == CH_NUL) begin
                    a_v    = 1'b1;
                    n_mode = M_HALT;
                end else if (r_mode == M_BSTAR && b == CH_SLASH) begin
                    n_mode = M_START;
                end else begin
                    n_mode = (b == CH_STAR) ? M_BSTAR : M_BLOCK;
                    n_run  = incl;
                end
            end
            M_CHAR1: begin
                if (is_print(b) && b != CH_BSLASH && b != CH_QUOTE) begin
                    n_mode = M_CHAR2;
                    n_run  = incl;
                end else begin
                    a_v    = 1'b1;
                    n_mode = M_HALT;
                end
            end
            M_CHAR2: begin
                a_v = 1'b1;
                if (b == CH_QUOTE) begin
                    a_kind = K_LIT;
                    a_attr = A_CHAR;
                    n_mode = M_START;
                end else begin
                    n_mode = M_HALT;
                end
            end
            M_STRING: begin
                if (b == CH_DQUOTE) begin
                    a_v    = 1'b1;
                    a_kind = K_LIT;
                    a_attr = A_STR;
                    n_mode = M_START;
                end else if (is_print(b)) begin
                    n_run = incl;
                end else begin
                    a_v    = 1'b1;
                    n_mode = M_HALT;
                end
            end
            M_IDENT: begin
                if (is_alpha(b) || is_digit(b) || b == CH_USCORE) begin
                    n_run = incl;
                end else begin
                    a_v      = 1'b1;
                    a_kind   = K_ID;
                    a_len    = r_run;
                    do_begin = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_digit(b)) begin
                    n_run = incl;
                end else begin
                    a_v      = 1'b1;
                    a_kind   = K_NUM;
                    a_len    = r_run;
                    do_begin = 1'b1;
                end
            end
            M_OPER: begin
                a_v = 1'b1;
                if (r_op >= OP_EQ && r_op <= OP_NOT) begin
                    a_kind = K_RELOP;
                    if (b == CH_EQ) begin
                        unique case (r_op)
                            OP_EQ:   a_attr = A_EQ;
                            OP_GT:   a_attr = A_GE;
                            OP_LT:   a_attr = A_LE;
                            default: a_attr = A_NE;
                        endcase
                        n_mode = M_START;
                        n_op   = OP_NONE;
                    end else begin
                        // lone operator, the byte opens the next token
                        unique case (r_op)
                            OP_EQ:   a_attr = A_NONE;
                            OP_GT:   a_attr = A_GT;
                            OP_LT:   a_attr = A_LT;
                            default: a_attr = A_NOT;
                        endcase
                        if (r_op == OP_EQ) begin
                            a_kind = K_ASSIGN;
                        end
                        a_len    = LEN_BITS'(1);
                        do_begin = 1'b1;
                    end
                end else if (r_op == OP_AMP && b == CH_AMP) begin
                    a_kind = K_RELOP;
                    a_attr = A_AND;
                    n_mode = M_START;
                    n_op   = OP_NONE;
                end else if (r_op == OP_BAR && b == CH_BAR) begin
                    a_kind = K_RELOP;
                    a_attr = A_OR;
                    n_mode = M_START;
                    n_op   = OP_NONE;
                end else begin
                    n_mode = M_HALT;
                end
            end
            M_HALT: begin
                n_mode = M_HALT;
            end
            default: begin
                do_begin = 1'b1;
            end
        endcase

        if (do_begin) begin
            n_mode  = bg.mode;
            n_op    = bg.op;
            n_start = r_pos;
            n_run   = LEN_BITS'(1);
        end

        if (r_mode == M_HALT) begin
            n_pos = r_pos;
        end else if (do_begin && bg.eof) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POSITION_BITS'(1);
        end
    end

    assign b_v = do_begin && bg.emit;

    always_comb begin
        t_token tb;
        tb.kind   = bg.kind;
        tb.attr   = A_NONE;
        tb.start  = 16'(r_pos);
        tb.length = bg.len_one ? LEN_BITS'(1) : '0;
        tb.last   = 1'b1;
        e1        = tb;
        if (a_v) begin
            e0.kind   = a_kind;
            e0.attr   = a_attr;
            e0.start  = 16'(r_start);
            e0.length = a_len;
            e0.last   = !b_v;
        end else begin
            e0 = tb;
        end
        n_push = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
    end

    assign n_cnt = r_cnt + (FIFO_PTR_BITS+1)'(n_push) - (FIFO_PTR_BITS+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_START;
            r_pos   <= '0;
            r_start <= '0;
            r_op    <= OP_NONE;
            r_run   <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_op    <= n_op;
                r_run   <= n_run;
            end
            r_wr  <= r_wr + FIFO_PTR_BITS'(n_push);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rd <= r_rd + FIFO_PTR_BITS'(1);
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr] <= e0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr + FIFO_PTR_BITS'(1)] <= e1;
        end
    end

    assign o_in_stall     = (r_cnt > (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));
    assign o_out_valid    = (r_cnt != '0);
    assign o_token_kind   = r_fifo[r_rd].kind;
    assign o_token_attr   = r_fifo[r_rd].attr;
    assign o_token_start  = r_fifo[r_rd].start;
    assign o_token_length = r_fifo[r_rd].length;
    assign o_last_of_run  = r_fifo[r_rd].last;

endmodule

// File: rtl/stt_checker.sv
// port-level checks for the source text tokenizer, bound to the top level
module stt_checker
    import stt_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic [7:0]          i_text_byte,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [4:0]          o_token_kind,
    input logic [3:0]          o_token_attr,
    input logic [15:0]         o_token_start,
    input logic [LEN_BITS-1:0] o_token_length,
    input logic                o_last_of_run
);

    // a held token keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_kind)
        && $stable(o_token_attr) && $stable(o_token_start)
        && $stable(o_token_length) && $stable(o_last_of_run))
        else $error("token changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token shown right after reset");

    // only literals and relational operators carry an attribute
    a_attr_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != K_LIT && o_token_kind != K_RELOP
        |-> o_token_attr == A_NONE)
        else $error("attribute on a token kind that has none");

    // end of text has zero length and closes its run
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_EOF |-> o_token_length == '0 && o_last_of_run)
        else $error("malformed end of text token");

    // an error token is always the last one caused by its byte
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_ERR |-> o_last_of_run)
        else $error("error token followed by another token of the same byte");

endmodule

bind source_text_tokenizer_top stt_checker u_stt_checker (.*);

// File: tb/source_text_tokenizer_top_tb.sv
// testbench for the source text tokenizer: random and directed text, token-by-token compare
`timescale 1ns / 1ps

module source_text_tokenizer_top_tb
    import stt_pkg::*;
;

    localparam logic [1:0] PH_SLOW_RX = 2'd0;
    localparam logic [1:0] PH_SLOW_TX = 2'd1;
    localparam logic [1:0] PH_FULL    = 2'd2;

    localparam string ALNUM =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789_";

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] value;
    } t_text_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_text_byte = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [4:0]          o_token_kind;
    logic [3:0]          o_token_attr;
    logic [15:0]         o_token_start;
    logic [LEN_BITS-1:0] o_token_length;
    logic                o_last_of_run;

    t_text_word source_bytes[$];
    t_token     tokens_due[$];
    t_token     step_toks[$];
    t_token     head_tok;
    logic [1:0] fill_phase = PH_SLOW_RX;
    logic [1:0] rx_phase = PH_SLOW_RX;
    bit         failed = 1'b0;

    // scanner state as the testbench sees it
    t_mode       scan_st = M_START;
    logic [15:0] pos = '0;
    logic [15:0] tok_start = '0;
    logic [2:0]  pend_op = OP_NONE;
    logic [15:0] run_len = '0;
    bit          saw_eof;

    source_text_tokenizer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_attr   (o_token_attr),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit letter_ch(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic bit digit_ch(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit print_ch(input logic [7:0] b);
        return b >= 8'd32 && b <= 8'd126;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        case (b)
            "+":     return K_PLUS;
            "-":     return K_MINUS;
            "*":     return K_MULT;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            ";":     return K_SEMI;
            ",":     return K_COMMA;
            default: return K_EOF;
        endcase
    endfunction

    function automatic logic [2:0] op_of(input logic [7:0] b);
        case (b)
            "=":     return OP_EQ;
            ">":     return OP_GT;
            "<":     return OP_LT;
            "!":     return OP_NOT;
            "&":     return OP_AMP;
            "|":     return OP_BAR;
            default: return OP_NONE;
        endcase
    endfunction

    function automatic logic [3:0] relop_attr(input logic [2:0] op, input bit with_eq);
        case (op)
            OP_EQ:   return with_eq ? A_EQ : A_NONE;
            OP_GT:   return with_eq ? A_GE : A_GT;
            OP_LT:   return with_eq ? A_LE : A_LT;
            OP_NOT:  return with_eq ? A_NE : A_NOT;
            default: return A_NONE;
        endcase
    endfunction

    function automatic void put_token(input logic [4:0] kind, input logic [3:0] attr,
                                      input logic [15:0] start, input logic [15:0] len);
        t_token t;
        t.kind   = kind;
        t.attr   = attr;
        t.start  = start;
        t.length = len;
        t.last   = 1'b0;
        step_toks.insert(step_toks.size(), t);
    endfunction

    function automatic void halt_with(input logic [15:0] len);
        put_token(K_ERR, A_NONE, tok_start, len);
        scan_st = M_HALT;
    endfunction

    // a byte seen with no token open
    function automatic void open_token(input logic [15:0] p, input logic [7:0] b);
        scan_st   = M_START;
        pend_op   = OP_NONE;
        tok_start = p;
        run_len   = 16'd1;
        if (b == CH_NUL) begin
            put_token(K_EOF, A_NONE, p, 16'd0);
            saw_eof = 1'b1;
        end else if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) begin
            // whitespace opens nothing
        end else if (punct_kind(b) != K_EOF) begin
            put_token(punct_kind(b), A_NONE, p, 16'd1);
        end else if (op_of(b) != OP_NONE) begin
            pend_op = op_of(b);
            scan_st = M_OPER;
        end else if (b == CH_SLASH) begin
            scan_st = M_SLASH;
        end else if (b == CH_QUOTE) begin
            scan_st = M_CHAR1;
        end else if (b == CH_DQUOTE) begin
            scan_st = M_STRING;
        end else if (letter_ch(b)) begin
            scan_st = M_IDENT;
        end else if (digit_ch(b)) begin
            scan_st = M_NUMBER;
        end else begin
            halt_with(16'd1);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic [15:0] p;
        logic [15:0] incl;
        t_token      t;
        if (scan_st == M_HALT) return;
        p    = pos;
        incl = (run_len == 16'hFFFF) ? run_len : run_len + 16'd1;
        step_toks.delete();
        saw_eof = 1'b0;
        case (scan_st)
            M_SLASH: begin
                if (b == CH_SLASH) begin
                    scan_st = M_LINE;
                    run_len = incl;
                end else if (b == CH_STAR) begin
                    scan_st = M_BLOCK;
                    run_len = incl;
                end else begin
                    put_token(K_DIV, A_NONE, tok_start, 16'd1);
                    open_token(p, b);
                end
            end
            M_LINE: begin
                if (b == CH_NL) scan_st = M_START;
                else if (b == CH_NUL) open_token(p, b);
            end
            M_BLOCK, M_BSTAR: begin
                if (b == CH_NUL) begin
                    halt_with(incl);
                end else if (scan_st == M_BSTAR && b == CH_SLASH) begin
                    scan_st = M_START;
                end else begin
                    if (b == CH_STAR) scan_st = M_BSTAR;
                    else scan_st = M_BLOCK;
                    run_len = incl;
                end
            end
            M_CHAR1: begin
                if (print_ch(b) && b != CH_BSLASH && b != CH_QUOTE) begin
                    scan_st = M_CHAR2;
                    run_len = incl;
                end else begin
                    halt_with(incl);
                end
            end
            M_CHAR2: begin
                if (b == CH_QUOTE) begin
                    put_token(K_LIT, A_CHAR, tok_start, incl);
                    scan_st = M_START;
                end else begin
                    halt_with(incl);
                end
            end
            M_STRING: begin
                if (b == CH_DQUOTE) begin
                    put_token(K_LIT, A_STR, tok_start, incl);
                    scan_st = M_START;
                end else if (print_ch(b)) begin
                    run_len = incl;
                end else begin
                    halt_with(incl);
                end
            end
            M_IDENT: begin
                if (letter_ch(b) || digit_ch(b) || b == CH_USCORE) begin
                    run_len = incl;
                end else begin
                    put_token(K_ID, A_NONE, tok_start, run_len);
                    open_token(p, b);
                end
            end
            M_NUMBER: begin
                if (digit_ch(b)) begin
                    run_len = incl;
                end else begin
                    put_token(K_NUM, A_NONE, tok_start, run_len);
                    open_token(p, b);
                end
            end
            M_OPER: begin
                case (pend_op)
                    OP_EQ, OP_GT, OP_LT, OP_NOT: begin
                        if (b == CH_EQ) begin
                            put_token(K_RELOP, relop_attr(pend_op, 1'b1), tok_start, incl);
                            scan_st = M_START;
                            pend_op = OP_NONE;
                        end else begin
                            put_token((pend_op == OP_EQ) ? K_ASSIGN : K_RELOP,
                                      relop_attr(pend_op, 1'b0), tok_start, 16'd1);
                            open_token(p, b);
                        end
                    end
                    OP_AMP, OP_BAR: begin
                        if (b == ((pend_op == OP_AMP) ? CH_AMP : CH_BAR)) begin
                            put_token(K_RELOP, (pend_op == OP_AMP) ? A_AND : A_OR,
                                      tok_start, incl);
                            scan_st = M_START;
                            pend_op = OP_NONE;
                        end else begin
                            halt_with(incl);
                        end
                    end
                    default: halt_with(incl);
                endcase
            end
            default: open_token(p, b);
        endcase
        pos = saw_eof ? 16'd0 : p + 16'd1;
        foreach (step_toks[i]) begin
            t      = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            tokens_due.insert(tokens_due.size(), t);
        end
    endfunction

    function automatic bit idle_draw(input logic [1:0] ph, input bit tx_side);
        int unsigned pct;
        if (ph == PH_SLOW_RX) pct = tx_side ? 25 : 79;
        else if (ph == PH_SLOW_TX) pct = tx_side ? 79 : 25;
        else pct = 0;
        return $urandom_range(99) < pct;
    endfunction

    function automatic void put_byte(input logic [7:0] v);
        t_text_word w;
        w.phase = fill_phase;
        w.value = v;
        source_bytes.insert(source_bytes.size(), w);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // one well-formed lexeme with random content
    function automatic void add_lexeme();
        int unsigned sel;
        logic [7:0]  v;
        bit          star;
        sel = $urandom_range(99);
        if (sel < 10) begin
            repeat ($urandom_range(1, 3)) put_byte(pick(" \t\n\r\013\014"));
        end else if (sel < 24) begin
            put_byte(pick("+-*()[]{};,"));
        end else if (sel < 34) begin
            put_byte(pick("=<>!"));
            if ($urandom_range(1)) put_byte(CH_EQ);
        end else if (sel < 39) begin
            v = $urandom_range(1) ? CH_AMP : CH_BAR;
            put_byte(v);
            put_byte(v);
        end else if (sel < 45) begin
            // the follower must not turn the slash into a comment
            put_byte(CH_SLASH);
            put_byte(pick(" \t\n(x7;+=-"));
        end else if (sel < 51) begin
            put_text("//");
            repeat ($urandom_range(0, 12)) begin
                do v = 8'($urandom_range(1, 255)); while (v == CH_NL);
                put_byte(v);
            end
            put_byte(($urandom_range(5) == 0) ? CH_NUL : CH_NL);
        end else if (sel < 57) begin
            put_text("/*");
            star = 1'b0;
            repeat ($urandom_range(0, 12)) begin
                case ($urandom_range(3))
                    0:       v = CH_STAR;
                    1:       v = CH_SLASH;
                    default: v = 8'($urandom_range(1, 255));
                endcase
                if (star && v == CH_SLASH) v = "x";
                put_byte(v);
                star = (v == CH_STAR);
            end
            put_text("*/");
        end else if (sel < 62) begin
            put_byte(CH_QUOTE);
            do v = 8'($urandom_range(32, 126)); while (v == CH_BSLASH || v == CH_QUOTE);
            put_byte(v);
            put_byte(CH_QUOTE);
        end else if (sel < 68) begin
            put_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 10)) begin
                do v = 8'($urandom_range(32, 126)); while (v == CH_DQUOTE);
                put_byte(v);
            end
            put_byte(CH_DQUOTE);
        end else if (sel < 84) begin
            put_byte(ALNUM[$urandom_range(51)]);
            repeat ($urandom_range(0, 8)) put_byte(pick(ALNUM));
        end else if (sel < 96) begin
            repeat ($urandom_range(1, 6)) put_byte(pick("0123456789"));
        end else begin
            put_byte(CH_NUL);
        end
    endfunction

    // the one malformed lexeme of the run; the scanner stays silent after it
    function automatic void add_error_case();
        repeat ($urandom_range(0, 3)) put_byte(" ");
        case ($urandom_range(7))
            0: put_text("_a");
            1: begin
                case ($urandom_range(2))
                    0:       put_byte(8'($urandom_range(128, 255)));
                    1:       put_byte(pick("@#$%^`~?:.\\"));
                    default: put_byte(8'($urandom_range(1, 8)));
                endcase
            end
            2: begin
                put_byte(CH_QUOTE);
                put_byte(pick("\\'\n"));
            end
            3: put_text("'ab'");
            4: begin
                put_text("\"ab");
                case ($urandom_range(2))
                    0:       put_byte(CH_NL);
                    1:       put_byte(CH_NUL);
                    default: put_byte(8'h9F);
                endcase
            end
            5: begin
                put_byte($urandom_range(1) ? CH_AMP : CH_BAR);
                put_byte("x");
            end
            6: begin
                put_text("/* a*");
                put_byte(CH_NUL);
            end
            default: put_text("'");
        endcase
        put_byte(CH_NUL);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // text side: one word per accept, next word loaded behind it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                scan_byte(i_text_byte);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (source_bytes.size() != 0 && !idle_draw(source_bytes[0].phase, 1'b1)) begin
                    i_text_byte <= source_bytes[0].value;
                    rx_phase    <= source_bytes[0].phase;
                    i_in_valid  <= 1'b1;
                    source_bytes.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // token side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (tokens_due.size() == 0) begin
                    $error("token kind %0d at %0d arrived with none due",
                           o_token_kind, o_token_start);
                    failed = 1'b1;
                end else begin
                    head_tok = tokens_due.pop_front();
                    check_field("token_kind", head_tok.kind, o_token_kind);
                    check_field("token_attr", head_tok.attr, o_token_attr);
                    check_field("token_start", head_tok.start, o_token_start);
                    check_field("token_length", head_tok.length, o_token_length);
                    check_field("last_of_run", head_tok.last, o_last_of_run);
                end
            end
            i_out_stall <= idle_draw(rx_phase, 1'b0);
        end
    end

    initial begin
        int base;

        fill_phase = PH_SLOW_RX;
        put_text("+-*/ ()[]{};,'a' \"q\\'~\" Ab_9 0 9876 = == > >= < <= ! != && || x/3 ");
        put_text("//c");
        put_byte(8'hFF);
        put_byte(CH_NL);
        // the opening star cannot close the comment
        put_text("/*/");
        put_byte(8'h80);
        put_text("**/ab=");
        put_byte(CH_NUL);
        put_text("// end");
        put_byte(CH_NUL);

        base = source_bytes.size();
        while (source_bytes.size() - base < 950) begin
            if (source_bytes.size() - base < 317) fill_phase = PH_SLOW_RX;
            else if (source_bytes.size() - base < 634) fill_phase = PH_SLOW_TX;
            else fill_phase = PH_FULL;
            add_lexeme();
        end
        put_byte(CH_NUL);

        add_error_case();
        repeat (20) put_byte(8'($urandom_range(255)));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (source_bytes.size() != 0 || i_in_valid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("source_text_tokenizer_top_tb OK");
        end else begin
            $display("source_text_tokenizer_top_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("source_text_tokenizer_top_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
rtl/stt_pkg.sv
rtl/source_text_tokenizer_top.sv
rtl/stt_checker.sv
tb/source_text_tokenizer_top_tb.sv
